// ===== sv/sle_pkg.sv =====
// Package: types, codes and command/status structs for the sorted list engine
`timescale 1ns / 1ps
package sle_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_DUMP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ES_VALUE = 2'd0,
        ES_READ  = 2'd1,
        ES_ZERO  = 2'd2
    } entry_sel_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] entry;
        logic               last;
    } out_t;

    typedef struct packed {
        logic       load;
        logic       rd;
        logic       wr_up;
        logic       wr_new;
        logic       wr_down;
        logic       set_found;
        logic       idx_inc;
        logic       cnt_dec;
        logic       emit;
        status_t    emit_status;
        entry_sel_t emit_sel;
        logic       emit_last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       cnt_zero;
        logic       idx_zero;
        logic       idx_one;
        logic       last_entry;
        logic       less;
        logic       equal;
        logic       found;
        logic       out_free;
    } stat_t;

endpackage

// ===== sv/sle_ctrl.sv =====
// Controller: sequences insert, delete, search and dump over the datapath
`timescale 1ns / 1ps
module sle_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  sle_pkg::stat_t stat,
    output sle_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_RD,
        S_CMP,
        S_PLACE,
        S_EMIT
    } state_t;

    state_t               state_reg, state_next;
    sle_pkg::status_t     emit_status_reg, emit_status_next;
    sle_pkg::entry_sel_t  emit_sel_reg, emit_sel_next;
    logic                 emit_last_reg, emit_last_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        emit_status_next = emit_status_reg;
        emit_sel_next    = emit_sel_reg;
        emit_last_next   = emit_last_reg;
        cmd              = '0;
        cmd.emit_status  = emit_status_reg;
        cmd.emit_sel     = emit_sel_reg;
        cmd.emit_last    = emit_last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                emit_sel_next  = sle_pkg::ES_VALUE;
                emit_last_next = 1'b1;
                case (stat.op)
                    sle_pkg::OP_INSERT:
                    begin
                        if (stat.full)
                        begin
                            emit_status_next = sle_pkg::ST_FULL;
                            state_next       = S_EMIT;
                        end
                        else if (stat.idx_zero)
                            state_next = S_PLACE;
                        else
                            state_next = S_RD;
                    end
                    sle_pkg::OP_DUMP:
                    begin
                        if (stat.cnt_zero)
                        begin
                            emit_status_next = sle_pkg::ST_EMPTY;
                            emit_sel_next    = sle_pkg::ES_ZERO;
                            state_next       = S_EMIT;
                        end
                        else
                            state_next = S_RD;
                    end
                    default:
                    begin
                        if (stat.cnt_zero)
                        begin
                            emit_status_next = sle_pkg::ST_NOT_FOUND;
                            state_next       = S_EMIT;
                        end
                        else
                            state_next = S_RD;
                    end
                endcase
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                case (stat.op)
                    sle_pkg::OP_INSERT:
                    begin
                        if (stat.less)
                        begin
                            cmd.wr_up  = 1'b1;
                            state_next = stat.idx_one ? S_PLACE : S_RD;
                        end
                        else
                            state_next = S_PLACE;
                    end
                    sle_pkg::OP_DELETE:
                    begin
                        cmd.idx_inc = 1'b1;
                        if (stat.found)
                            cmd.wr_down = 1'b1;
                        else if (stat.equal)
                            cmd.set_found = 1'b1;
                        if (stat.last_entry)
                        begin
                            if (stat.found || stat.equal)
                            begin
                                cmd.cnt_dec      = 1'b1;
                                emit_status_next = sle_pkg::ST_DONE;
                            end
                            else
                                emit_status_next = sle_pkg::ST_NOT_FOUND;
                            state_next = S_EMIT;
                        end
                        else
                            state_next = S_RD;
                    end
                    sle_pkg::OP_SEARCH:
                    begin
                        if (stat.equal)
                        begin
                            emit_status_next = sle_pkg::ST_DONE;
                            state_next       = S_EMIT;
                        end
                        else if (stat.last_entry)
                        begin
                            emit_status_next = sle_pkg::ST_NOT_FOUND;
                            state_next       = S_EMIT;
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                            state_next  = S_RD;
                        end
                    end
                    default:
                    begin
                        emit_status_next = sle_pkg::ST_DONE;
                        emit_sel_next    = sle_pkg::ES_READ;
                        emit_last_next   = stat.last_entry;
                        state_next       = S_EMIT;
                    end
                endcase
            end
            S_PLACE:
            begin
                cmd.wr_new       = 1'b1;
                emit_status_next = sle_pkg::ST_DONE;
                state_next       = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if ((stat.op == sle_pkg::OP_DUMP) && !emit_last_reg)
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_RD;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            emit_status_reg <= sle_pkg::ST_DONE;
            emit_sel_reg    <= sle_pkg::ES_VALUE;
            emit_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            emit_status_reg <= emit_status_next;
            emit_sel_reg    <= emit_sel_next;
            emit_last_reg   <= emit_last_next;
        end
    end

endmodule

// ===== sv/sle_dp.sv =====
// Datapath: entry memory, count, scan index, request registers and output register
`timescale 1ns / 1ps
module sle_dp
#(
    parameter int CAPACITY = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  sle_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output sle_pkg::out_t  out_data,
    input  sle_pkg::cmd_t  cmd,
    output sle_pkg::stat_t stat
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic signed [31:0] mem [CAPACITY];

    logic [CW-1:0]      count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic               found_reg, found_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [1:0]         op_reg;
    logic signed [31:0] val_reg;
    logic signed [31:0] rd_data_reg;
    sle_pkg::out_t      out_data_reg;

    logic [CW-1:0]      idx_m1;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic signed [31:0] emit_entry;

    assign idx_m1  = idx_reg - CW'(1);
    assign rd_addr = (op_reg == sle_pkg::OP_INSERT) ? idx_m1[AW-1:0] : idx_reg[AW-1:0];

    always_comb
    begin
        wr_en   = cmd.wr_up || cmd.wr_new || cmd.wr_down;
        wr_addr = idx_reg[AW-1:0];
        wr_data = rd_data_reg;
        if (cmd.wr_new)
            wr_data = val_reg;
        if (cmd.wr_down)
            wr_addr = idx_m1[AW-1:0];
    end

    always_comb
    begin
        case (cmd.emit_sel)
            sle_pkg::ES_READ: emit_entry = rd_data_reg;
            sle_pkg::ES_ZERO: emit_entry = '0;
            default:          emit_entry = val_reg;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.wr_new)
            count_next = count_reg + CW'(1);
        else if (cmd.cnt_dec)
            count_next = count_reg - CW'(1);

        found_next = found_reg;
        if (cmd.load)
            found_next = 1'b0;
        else if (cmd.set_found)
            found_next = 1'b1;

        idx_next = idx_reg;
        if (cmd.load)
            idx_next = (in_data.opcode == sle_pkg::OP_INSERT) ? count_reg : '0;
        else if (cmd.wr_up)
            idx_next = idx_m1;
        else if (cmd.idx_inc)
            idx_next = idx_reg + CW'(1);

        if (cmd.emit)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            op_reg  <= in_data.opcode;
            val_reg <= in_data.value;
        end
        if (cmd.rd)
            rd_data_reg <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.emit)
        begin
            out_data_reg.status <= cmd.emit_status;
            out_data_reg.entry  <= emit_entry;
            out_data_reg.last   <= cmd.emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign stat.op         = op_reg;
    assign stat.full       = (count_reg == CW'(CAPACITY));
    assign stat.cnt_zero   = (count_reg == '0);
    assign stat.idx_zero   = (idx_reg == '0);
    assign stat.idx_one    = (idx_reg == CW'(1));
    assign stat.last_entry = ((idx_reg + CW'(1)) == count_reg);
    assign stat.less       = (rd_data_reg < val_reg);
    assign stat.equal      = (rd_data_reg == val_reg);
    assign stat.found      = found_reg;
    assign stat.out_free   = !out_valid_reg || !out_stall;

endmodule

// ===== sv/sorted_list_engine_top.sv =====
// Top level: sorted list engine, controller plus datapath
// Usage:
//   in_data carries an opcode (insert, delete, search, dump) and a signed value.
//   A transaction on either channel completes when valid is high and stall is low.
//   in_stall is low only while the engine is idle; one request is worked at a time.
//   Insert, delete and search return one result with last set. Dump returns one
//   result per stored entry, head (largest) to tail, last set on the final one;
//   an empty table gives a single result with status empty and entry zero.
// Scanning, with n the number of stored entries:
//   insert scans from the tail, moving the k smaller entries towards the tail;
//   a full table answers without a scan; delete scans all n entries; search
//   scans up to n entries, stopping at a match; dump takes one scan step per
//   entry. Every scan step is a read state and a compare state because
//   the entry memory has one registered read port.
// Reset clears the entry count and the output valid flag; memory contents are
//   not cleared, and no clearing pass is needed.
// When out_stall is high the result holds in the output register; the engine
//   waits for it only when it has a further result to hand over.
`timescale 1ns / 1ps
module sorted_list_engine_top
#(
    parameter int CAPACITY = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  sle_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output sle_pkg::out_t out_data
);

    sle_pkg::cmd_t  cmd;
    sle_pkg::stat_t stat;

    sle_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    sle_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== sv/sle_checker.sv =====
// Checker: port-level properties of the sorted list engine, bound to the top level
`timescale 1ns / 1ps
module sle_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input sle_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_stall,
    input sle_pkg::out_t out_data
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("stalled request changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction accepted while busy");

    a_not_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> out_data.status == sle_pkg::ST_DONE)
        else $error("non-final result with error status");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == sle_pkg::ST_FULL
                   || out_data.status == sle_pkg::ST_NOT_FOUND
                   || out_data.status == sle_pkg::ST_EMPTY) |-> out_data.last)
        else $error("error status without last");

endmodule

bind sorted_list_engine_top sle_checker u_sle_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== tb/tb.sv =====
// Testbench for the sorted list engine: directed table, random traffic and a self-checking predictor
`timescale 1ns / 1ps
module tb;

    localparam int CAPACITY    = 16;
    localparam int RAND_ITEMS  = 155;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 100;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT     = 60;
    localparam int QUIET_FROM  = 120;
    localparam int QUIET_TO    = 150;
    localparam int IDLE_PCT    = 27;

    localparam logic signed [31:0] VMAX = 32'sh7fffffff;
    localparam logic signed [31:0] VMIN = 32'sh80000000;

    typedef struct {
        sle_pkg::in_t  req;
        bit            typed;
        sle_pkg::out_t want;
    } stim_row_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_stall;
    sle_pkg::in_t  in_data   = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    sle_pkg::out_t out_data;

    stim_row_t          stim_rows[$];
    sle_pkg::out_t      expected_results[$];
    logic signed [31:0] shadow_entries[CAPACITY];
    int                 shadow_count = 0;
    int                 n_sent       = 0;
    int                 mismatches   = 0;
    int                 cycles       = 0;
    int                 hold_left    = 0;
    bit                 hold_done    = 1'b0;
    logic               quiet;

    sorted_list_engine_top #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always #4 clk = ~clk;

    assign quiet = (n_sent >= QUIET_FROM) && (n_sent < QUIET_TO);

    task automatic report_mismatch(input string what);
        if (mismatches < 50)
        begin
            $display("MISMATCH cycle %0d: %s", cycles, what);
        end
        mismatches++;
    endtask

    function automatic int find_entry(input logic signed [31:0] v);
        int i;
        for (i = 0; i < shadow_count; i++)
        begin
            if (shadow_entries[i] == v)
            begin
                return i;
            end
        end
        return shadow_count;
    endfunction

    // Advance the shadow table by one request; queue its results when asked.
    task automatic apply_request(input sle_pkg::in_t req, input bit emit);
        logic signed [31:0] v;
        int                 pos;
        int                 i;
        bit                 single;
        sle_pkg::out_t      res;
        v          = req.value;
        single     = 1'b1;
        res.status = sle_pkg::ST_DONE;
        res.entry  = v;
        res.last   = 1'b1;
        case (sle_pkg::op_t'(req.opcode))
            sle_pkg::OP_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                begin
                    res.status = sle_pkg::ST_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < shadow_count && shadow_entries[pos] >= v)
                    begin
                        pos++;
                    end
                    for (i = shadow_count; i > pos; i--)
                    begin
                        shadow_entries[i] = shadow_entries[i - 1];
                    end
                    shadow_entries[pos] = v;
                    shadow_count++;
                end
            end
            sle_pkg::OP_DELETE:
            begin
                pos = find_entry(v);
                if (pos >= shadow_count)
                begin
                    res.status = sle_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    for (i = pos; i + 1 < shadow_count; i++)
                    begin
                        shadow_entries[i] = shadow_entries[i + 1];
                    end
                    shadow_count--;
                end
            end
            sle_pkg::OP_SEARCH:
            begin
                if (find_entry(v) >= shadow_count)
                begin
                    res.status = sle_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                if (shadow_count == 0)
                begin
                    res.status = sle_pkg::ST_EMPTY;
                    res.entry  = '0;
                end
                else
                begin
                    single = 1'b0;
                    for (i = 0; i < shadow_count; i++)
                    begin
                        res.entry = shadow_entries[i];
                        res.last  = (i + 1 == shadow_count);
                        if (emit)
                        begin
                            expected_results.push_back(res);
                        end
                    end
                end
            end
        endcase
        if (emit && single)
        begin
            expected_results.push_back(res);
        end
    endtask

    task automatic add_row(input sle_pkg::op_t op, input logic signed [31:0] v);
        stim_row_t row;
        row.req.opcode = op;
        row.req.value  = v;
        row.typed      = 1'b0;
        row.want       = '0;
        stim_rows.push_back(row);
    endtask

    task automatic add_typed(input sle_pkg::op_t op, input logic signed [31:0] v,
                             input sle_pkg::status_t st, input logic signed [31:0] e);
        stim_row_t row;
        row.req.opcode  = op;
        row.req.value   = v;
        row.typed       = 1'b1;
        row.want.status = st;
        row.want.entry  = e;
        row.want.last   = 1'b1;
        stim_rows.push_back(row);
    endtask

    task automatic build_directed();
        add_typed(sle_pkg::OP_DUMP,   32'sd0, sle_pkg::ST_EMPTY,     32'sd0);
        add_typed(sle_pkg::OP_DELETE, 32'sd5, sle_pkg::ST_NOT_FOUND, 32'sd5);
        add_typed(sle_pkg::OP_SEARCH, 32'sd0, sle_pkg::ST_NOT_FOUND, 32'sd0);
        add_row(sle_pkg::OP_INSERT, VMAX);
        add_row(sle_pkg::OP_INSERT, VMIN);
        add_row(sle_pkg::OP_INSERT, 32'sd0);
        add_row(sle_pkg::OP_INSERT, 32'sd0);
        add_row(sle_pkg::OP_INSERT, -32'sd1);
        add_row(sle_pkg::OP_INSERT, 32'sd1);
        add_row(sle_pkg::OP_INSERT, VMAX);
        add_row(sle_pkg::OP_INSERT, VMIN);
        add_row(sle_pkg::OP_INSERT, 32'sh12345678);
        add_row(sle_pkg::OP_INSERT, 32'shedcba988);
        add_row(sle_pkg::OP_INSERT, 32'sh55555555);
        add_row(sle_pkg::OP_INSERT, 32'shaaaaaaaa);
        add_row(sle_pkg::OP_INSERT, 32'sd2);
        add_row(sle_pkg::OP_INSERT, -32'sd2);
        add_row(sle_pkg::OP_INSERT, 32'sd100);
        add_row(sle_pkg::OP_INSERT, -32'sd100);
        add_typed(sle_pkg::OP_INSERT, 32'sd7, sle_pkg::ST_FULL,      32'sd7);
        add_row(sle_pkg::OP_DUMP, 32'shffffffff);
        add_row(sle_pkg::OP_DELETE, 32'sd0);
        add_row(sle_pkg::OP_DELETE, 32'sd3);
        add_row(sle_pkg::OP_SEARCH, VMAX);
        add_row(sle_pkg::OP_SEARCH, VMIN);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VMAX;
            1:       return VMIN;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4:       return 32'sd1;
            5:       return 32'sd42;
            6:       return -32'sd42;
            default: return $urandom;
        endcase
    endfunction

    // Alternate phases that favour inserts with phases that favour deletes.
    task automatic build_random();
        int           i;
        int           r;
        bit           grow;
        sle_pkg::op_t op;
        for (i = 0; i < RAND_ITEMS; i++)
        begin
            grow = ((i / 30) % 2) == 0;
            r    = $urandom_range(0, 99);
            if (grow)
            begin
                op = (r < 60) ? sle_pkg::OP_INSERT :
                     (r < 75) ? sle_pkg::OP_DELETE :
                     (r < 90) ? sle_pkg::OP_SEARCH : sle_pkg::OP_DUMP;
            end
            else
            begin
                op = (r < 20) ? sle_pkg::OP_INSERT :
                     (r < 65) ? sle_pkg::OP_DELETE :
                     (r < 85) ? sle_pkg::OP_SEARCH : sle_pkg::OP_DUMP;
            end
            add_row(op, pick_value());
        end
    endtask

    always @(posedge clk)
    begin
        int nxt;
        nxt = n_sent;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (stim_rows[nxt].typed)
                begin
                    expected_results.push_back(stim_rows[nxt].want);
                    apply_request(in_data, 1'b0);
                end
                else
                begin
                    apply_request(in_data, 1'b1);
                end
                nxt++;
                n_sent <= nxt;
            end
            if (!in_valid || !in_stall)
            begin
                if (nxt < stim_rows.size() && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    in_data  <= stim_rows[nxt].req;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (!hold_done && n_sent >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (quiet)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        sle_pkg::out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transaction status %0d entry %0d last %0d",
                                          out_data.status, out_data.entry, out_data.last));
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.status !== want.status)
                begin
                    report_mismatch($sformatf("status %0d, want %0d",
                                              out_data.status, want.status));
                end
                if (out_data.entry !== want.entry)
                begin
                    report_mismatch($sformatf("entry %0d, want %0d", out_data.entry, want.entry));
                end
                if (out_data.last !== want.last)
                begin
                    report_mismatch($sformatf("last %0d, want %0d", out_data.last, want.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("sorted_list_engine_top test failed");
            $finish;
        end
    end

    initial
    begin
        build_directed();
        build_random();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        while (n_sent < stim_rows.size() || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("sorted_list_engine_top test passed");
        end
        else
        begin
            $display("sorted_list_engine_top test failed");
        end
        $finish;
    end

endmodule
